// ===== sv/mpq_pkg.sv =====
package mpq_pkg;

    localparam int KEY_W            = 32;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int OCC_W            = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_FIND    = 2'd1,
        OP_EXTRACT = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic ins;
        logic ext;
    } t_cell_ctrl;

endpackage

// ===== sv/mpq_cell.sv =====
module mpq_cell #(
    parameter int CNT_W = $clog2(mpq_pkg::DEFAULT_CAPACITY + 1),
    parameter int IDX   = 0
) (
    input  logic                             i_clk,
    input  mpq_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [mpq_pkg::KEY_W-1:0] i_key_new,
    input  logic [CNT_W-1:0]                 i_count,
    input  logic signed [mpq_pkg::KEY_W-1:0] i_left_key,
    input  logic                             i_left_ge,
    input  logic signed [mpq_pkg::KEY_W-1:0] i_right_key,
    output logic signed [mpq_pkg::KEY_W-1:0] o_key,
    output logic                             o_ge
);

    logic signed [mpq_pkg::KEY_W-1:0] r_key;
    logic signed [mpq_pkg::KEY_W-1:0] n_key;

    // The new key belongs at or before this cell when the cell is empty or
    // holds a larger key. The chain is sorted, so this flag is monotonic.
    assign o_ge = (CNT_W'(IDX) >= i_count) || (i_key_new < r_key);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins && o_ge) begin
            n_key = i_left_ge ? i_left_key : i_key_new;
        end else if (i_ctrl.ext) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== sv/min_priority_queue_core.sv =====
// Bounded min-priority queue of signed 32-bit keys.
// Requests arrive on the s_axis channel: tuser carries the operation (insert,
// find minimum, extract minimum) and tdata the key to insert. Each request
// produces exactly one transaction on the m_axis channel carrying the smallest
// key (for a successful find or extract), a status and the occupancy after
// the request.
// The keys live in a chain of cells kept in ascending order, so the minimum
// always sits in the first cell. An insert makes every cell compare the new
// key with its own and either keep, take the new key or take its left
// neighbour's key; an extract shifts every cell one place towards the head.
// The result of a request is registered, so it appears on m_axis in the cycle
// after the request is accepted; a new request may be accepted every cycle
// while the receiver keeps taking results. One 32-bit compare per cell sets
// the clock rate. A single output register separates the two sides; while it
// holds a result the receiver has not taken, s_axis_tready stays low, and it
// rises again in the cycle the result is taken.
// Reset empties the queue and clears the output valid flag; the key store is
// not cleared, since cells beyond the occupancy are never read.
module min_priority_queue_core #(
    parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] key_in
    input  logic [1:0]  s_axis_tuser,  // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] key_out, [38:32] occupancy, [39] zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [mpq_pkg::KEY_W-1:0] w_key [CAPACITY];
    logic                             w_ge  [CAPACITY];

    mpq_pkg::t_cell_ctrl              w_ctrl;
    logic                             w_accept;
    logic                             w_full;
    logic                             w_empty;
    logic signed [mpq_pkg::KEY_W-1:0] w_key_in;

    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             r_out_valid;
    logic signed [mpq_pkg::KEY_W-1:0] r_key_out;
    logic signed [mpq_pkg::KEY_W-1:0] n_key_out;
    mpq_pkg::t_status                 r_status;
    mpq_pkg::t_status                 n_status;
    logic [mpq_pkg::OCC_W-1:0]        r_occ;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(CAPACITY));
    assign w_empty       = (r_count == '0);
    assign w_key_in      = s_axis_tdata;

    always_comb begin
        w_ctrl    = '0;
        n_count   = r_count;
        n_key_out = '0;
        n_status  = mpq_pkg::ST_OK;
        case (mpq_pkg::t_op'(s_axis_tuser))
            mpq_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = mpq_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + 1'b1;
                end
            end
            mpq_pkg::OP_FIND: begin
                if (w_empty) begin
                    n_status = mpq_pkg::ST_EMPTY;
                end else begin
                    n_key_out = w_key[0];
                end
            end
            mpq_pkg::OP_EXTRACT: begin
                if (w_empty) begin
                    n_status = mpq_pkg::ST_EMPTY;
                end else begin
                    n_key_out  = w_key[0];
                    w_ctrl.ext = w_accept;
                    n_count    = r_count - 1'b1;
                end
            end
            default: begin
                // Unused code: no change, plain ok result.
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [mpq_pkg::KEY_W-1:0] w_left_key;
        logic                             w_left_ge;
        logic signed [mpq_pkg::KEY_W-1:0] w_right_key;

        if (g == 0) begin : g_head
            assign w_left_key = '0;
            assign w_left_ge  = 1'b0;
        end else begin : g_body
            assign w_left_key = w_key[g-1];
            assign w_left_ge  = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_key = '0;
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
        end

        mpq_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_key_new   (w_key_in),
            .i_count     (r_count),
            .i_left_key  (w_left_key),
            .i_left_ge   (w_left_ge),
            .i_right_key (w_right_key),
            .o_key       (w_key[g]),
            .o_ge        (w_ge[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key_out <= n_key_out;
            r_status  <= n_status;
            r_occ     <= mpq_pkg::OCC_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_occ, r_key_out};
    assign m_axis_tuser  = r_status;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy exceeds capacity");

    a_extract_dec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tuser == mpq_pkg::OP_EXTRACT && !w_empty
        |=> r_count == $past(r_count) - 1'b1)
        else $error("extract did not remove exactly one key");

    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> w_key[0] <= w_key[1])
        else $error("head of the chain is out of order");

    a_empty_occ : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == mpq_pkg::ST_EMPTY |-> r_occ == '0)
        else $error("empty status with non-zero occupancy");

endmodule

// ===== test/tb_min_priority_queue_core.sv =====
module tb_min_priority_queue_core;

    localparam int CAPACITY = mpq_pkg::DEFAULT_CAPACITY;
    localparam int PHASE_LEN = 150;
    localparam int PHASE_COUNT = 11;
    localparam int PAUSE_PHASE = 5;
    localparam logic [mpq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [mpq_pkg::KEY_W-1:0] key;
        mpq_pkg::t_status          status;
        logic [mpq_pkg::OCC_W-1:0] occ;
    } t_queue_reply;

    typedef struct packed {
        logic [mpq_pkg::OP_W-1:0]  op;
        logic [mpq_pkg::KEY_W-1:0] key;
        logic                      typed;
        t_queue_reply              want;
    } t_stim_row;

    localparam int ROW_COUNT = 23;

    // Rows marked typed carry their reply; the others are left to the predictor.
    t_stim_row directed_rows [ROW_COUNT] = '{
        '{mpq_pkg::OP_FIND,    32'h0000_0000, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_EMPTY, 7'd0}},
        '{mpq_pkg::OP_EXTRACT, 32'h1234_5678, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_EMPTY, 7'd0}},
        '{OP_UNUSED,           32'h0000_0005, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_OK,    7'd0}},
        '{mpq_pkg::OP_INSERT,  32'h7FFF_FFFF, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_OK,    7'd1}},
        '{mpq_pkg::OP_INSERT,  32'h8000_0000, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_OK,    7'd2}},
        '{mpq_pkg::OP_FIND,    32'hFFFF_FFFF, 1'b1,
          '{32'h8000_0000, mpq_pkg::ST_OK,    7'd2}},
        '{OP_UNUSED,           32'hFFFF_FFFF, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_OK,    7'd2}},
        '{mpq_pkg::OP_INSERT,  32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_INSERT,  32'hFFFF_FFFF, 1'b0, '0},
        '{mpq_pkg::OP_INSERT,  32'h0000_0001, 1'b0, '0},
        '{mpq_pkg::OP_INSERT,  32'hFFFF_FFFF, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b1,
          '{32'h8000_0000, mpq_pkg::ST_OK,    7'd5}},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_FIND,    32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_INSERT,  32'h8000_0001, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b0, '0},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b1,
          '{32'h7FFF_FFFF, mpq_pkg::ST_OK,    7'd0}},
        '{mpq_pkg::OP_EXTRACT, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, mpq_pkg::ST_EMPTY, 7'd0}},
        '{mpq_pkg::OP_INSERT,  32'h5555_5555, 1'b0, '0},
        '{mpq_pkg::OP_INSERT,  32'hAAAA_AAAA, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [31:0] key_in
    logic [1:0]        s_axis_tuser = '0;   // [1:0] operation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;        // [31:0] key_out, [38:32] occupancy, [39] zero
    logic [1:0]        m_axis_tuser;        // [1:0] status

    // Travel alongside the request so the monitor sees them at acceptance.
    logic              row_typed = 1'b0;
    t_queue_reply      row_want = '0;

    logic [mpq_pkg::KEY_W-1:0] held_keys [CAPACITY];
    int                held_count = 0;
    t_queue_reply      awaited_replies [$];
    int                error_count = 0;
    int                idle_pct = 7;
    int                stall_pct = 7;

    min_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Keys are an unordered set; the minimum is found by a signed scan.
    function automatic t_queue_reply apply_request(logic [mpq_pkg::OP_W-1:0] op,
                                                   logic [mpq_pkg::KEY_W-1:0] key);
        t_queue_reply reply;
        int best;
        reply.key = '0;
        reply.status = mpq_pkg::ST_OK;
        best = 0;
        case (op)
            mpq_pkg::OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    reply.status = mpq_pkg::ST_FULL;
                end else begin
                    held_keys[held_count] = key;
                    held_count++;
                end
            end
            mpq_pkg::OP_FIND, mpq_pkg::OP_EXTRACT: begin
                if (held_count == 0) begin
                    reply.status = mpq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 1; i < held_count; i++) begin
                        if ($signed(held_keys[i]) < $signed(held_keys[best])) begin
                            best = i;
                        end
                    end
                    reply.key = held_keys[best];
                    if (op == mpq_pkg::OP_EXTRACT) begin
                        held_count--;
                        held_keys[best] = held_keys[held_count];
                    end
                end
            end
            default: ;
        endcase
        reply.occ = 7'(held_count);
        return reply;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("mismatch in %s: expected %h, got %h", field, want, got);
    endtask

    task automatic send_request(logic [mpq_pkg::OP_W-1:0] op, logic [mpq_pkg::KEY_W-1:0] key,
                                logic typed, t_queue_reply want);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
    endtask

    function automatic logic [mpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return 32'($signed($urandom_range(15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Phase bias: 0 fills towards full, 2 drains towards empty, others are mixed.
    function automatic logic [mpq_pkg::OP_W-1:0] pick_op(int bias);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) begin
            return OP_UNUSED;
        end
        case (bias)
            0: return (roll < 87) ? mpq_pkg::OP_INSERT :
                      (roll < 92) ? mpq_pkg::OP_FIND : mpq_pkg::OP_EXTRACT;
            2: return (roll < 12) ? mpq_pkg::OP_INSERT :
                      (roll < 22) ? mpq_pkg::OP_FIND : mpq_pkg::OP_EXTRACT;
            default: return (roll < 45) ? mpq_pkg::OP_INSERT :
                            (roll < 65) ? mpq_pkg::OP_FIND : mpq_pkg::OP_EXTRACT;
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_queue_reply reply;
        t_queue_reply front;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            reply = apply_request(s_axis_tuser, s_axis_tdata);
            awaited_replies.push_back(row_typed ? row_want : reply);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected transaction", '0, m_axis_tdata[31:0]);
            end else begin
                front = awaited_replies.pop_front();
                if (m_axis_tdata[31:0] !== front.key) begin
                    report_mismatch("key_out", front.key, m_axis_tdata[31:0]);
                end
                if (m_axis_tuser !== front.status) begin
                    report_mismatch("status", 32'(front.status), 32'(m_axis_tuser));
                end
                if (m_axis_tdata[38:32] !== front.occ) begin
                    report_mismatch("occupancy", 32'(front.occ), 32'(m_axis_tdata[38:32]));
                end
                if (m_axis_tdata[39] !== 1'b0) begin
                    report_mismatch("tdata padding", '0, 32'(m_axis_tdata[39]));
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].typed,
                         directed_rows[r].want);
        end
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == PAUSE_PHASE) begin
                drain_replies();
            end
            // Back-to-back traffic on both sides in phases 3 and 4 only.
            idle_pct  = (phase == 3 || phase == 4) ? 0 : 7;
            stall_pct = (phase == 3 || phase == 4) ? 0 : 7;
            for (int n = 0; n < PHASE_LEN; n++) begin
                send_request(pick_op(phase % 4), pick_key(), 1'b0, '0);
            end
        end
        drain_replies();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && awaited_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mpq_pkg.sv
sv/mpq_cell.sv
sv/min_priority_queue_core.sv
test/tb_min_priority_queue_core.sv
